[hdl/mwtg_pkg.sv]
// ----------------------------------------------------------------------------
// mwtg_pkg
// Types and constants for the multiwave tone generator: register map,
// waveform codes, noise generator and fixed-point scaling constants.
// ----------------------------------------------------------------------------
package mwtg_pkg;

    typedef enum logic [2:0] {
        CFG_WAVE_SELECT    = 3'd0,
        CFG_FREQ_STEP      = 3'd1,
        CFG_PHASE_OFFSET   = 3'd2,
        CFG_VOLUME_PERCENT = 3'd3,
        CFG_FORCE_PLAY     = 3'd4
    } t_cfg_reg;

    typedef enum logic [2:0] {
        WAVE_SINE     = 3'd0,
        WAVE_SQUARE   = 3'd1,
        WAVE_TRIANGLE = 3'd2,
        WAVE_SAWTOOTH = 3'd3,
        WAVE_NOISE    = 3'd4
    } t_wave;

    localparam int          CFG_INDEX_W   = 3;
    localparam int          CFG_DATA_W    = 32;

    localparam logic [15:0] LFSR_SEED     = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS     = 16'hB400;

    localparam logic [14:0] FULL_SCALE    = 15'h7FFF;
    localparam logic [14:0] SQ_DEADBAND   = 15'd32;

    localparam logic [6:0]  VOL_RESET     = 7'd100;
    localparam logic [6:0]  VOL_MAX       = 7'd100;
    localparam logic [5:0]  ROUND_HALF    = 6'd50;

    // floor(x / 100) == (x * DIV100_MUL) >> DIV100_SHIFT for x < 2^22
    localparam logic [22:0] DIV100_MUL    = 23'd5368710;
    localparam int          DIV100_SHIFT  = 29;

    // quarter-wave table generation (Q30 Taylor series of sin)
    localparam logic [63:0] HALF_PI_Q30   = 64'd1686629713;
    localparam int          TAYLOR_TERMS  = 9;
    localparam logic [63:0] TAYLOR_DIV [1:TAYLOR_TERMS] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342
    };

endpackage

[hdl/multiwave_tone_generator.sv]
// ----------------------------------------------------------------------------
// multiwave_tone_generator
// Direct digital synthesis tone source: sine, square, triangle, sawtooth
// or LFSR noise, scaled by a volume in percent, as signed Q1.15 samples.
// ----------------------------------------------------------------------------
// Usage
//   Input channel (i_valid / o_ready / i_play): each transfer is one sample
//   tick. The phase accumulator and the noise LFSR advance on every transfer,
//   sounding or not.
//   Output channel (o_valid / i_ready / o_sample): one sample per input
//   transfer, in order.
//   Config channel (i_cfg_valid / o_cfg_ready / i_cfg_index / i_cfg_data):
//   always ready; write only while no tick is in flight. Unknown indexes
//   are ignored.
//   A transfer moves through r_v1, r_v2, r_v3, r_vo to o_valid. Throughput:
//   one tick per cycle while i_ready is high, set by the four-stage pipeline
//   (phase/LFSR, waveform, gain multiply, divide-by-100 multiply with output
//   register). A stalled receiver holds the output register; stages behind it
//   keep filling bubbles, and o_ready drops once all four stages are full.
//   Reset: pipeline empty, accumulator zero, LFSR at its seed, volume 100,
//   all other configuration registers zero; sample data registers not reset.
// ----------------------------------------------------------------------------
module multiwave_tone_generator #(
    parameter int PHASE_BITS       = 32,
    parameter int SINE_TABLE_DEPTH = 256,
    parameter int SAMPLE_BITS      = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,

    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic                               i_play,

    output logic                               o_valid,
    input  logic                               i_ready,
    output logic signed [SAMPLE_BITS-1:0]      o_sample,

    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [mwtg_pkg::CFG_INDEX_W-1:0]   i_cfg_index,
    input  logic [mwtg_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import mwtg_pkg::*;

    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int LUT_AW = $clog2(SINE_TABLE_DEPTH);

    typedef logic [14:0] t_lut [SINE_TABLE_DEPTH];

    function automatic t_lut build_sine_lut();
        t_lut        lut;
        logic [63:0] x;
        logic [63:0] x2;
        logic [63:0] term;
        logic [63:0] sum;
        logic [63:0] v;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            x    = (HALF_PI_Q30 * 64'(i)) / 64'(SINE_TABLE_DEPTH);
            x2   = (x * x) >> 30;
            term = x;
            sum  = x;
            for (int k = 1; k <= TAYLOR_TERMS; k++) begin
                term = ((term * x2) >> 30) / TAYLOR_DIV[k];
                if (k % 2 == 1) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            v = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
            if (v > 64'(FULL_SCALE)) begin
                v = 64'(FULL_SCALE);
            end
            lut[i] = v[14:0];
        end
        return lut;
    endfunction

    localparam t_lut SINE_LUT = build_sine_lut();

    // configuration
    logic [2:0]            r_wave_sel;
    logic [31:0]           r_freq_step;
    logic [15:0]           r_phase_off;
    logic [6:0]            r_volume;
    logic                  r_force_play;

    // state
    logic [PHASE_BITS-1:0] r_accum;
    logic [15:0]           r_lfsr;
    logic [15:0]           n_lfsr;

    // pipeline
    logic                  r_v1, r_v2, r_v3, r_vo;
    logic                  adv1, adv2, adv3, adv_o;
    logic                  in_xfer;

    logic [15:0]           r_p1;
    logic [15:0]           r_noise1;
    logic                  r_act1;
    logic signed [15:0]    r_raw2;
    logic [21:0]           r_num3;
    logic                  r_neg3;
    logic signed [15:0]    r_sample;

    // stage 2 combinational
    logic [1:0]            quad;
    logic [IDX_W+13:0]     idx_prod;
    logic [IDX_W-1:0]      idx_fwd;
    logic [IDX_W-1:0]      idx;
    logic [14:0]           sine_mag;
    logic signed [15:0]    sine_val;
    logic [16:0]           tri_d;
    logic signed [15:0]    tri_val;
    logic signed [15:0]    n_raw;

    // stage 3 combinational
    logic [16:0]           raw_abs;
    logic [6:0]            vol_eff;
    logic [21:0]           num_full;

    // output stage combinational
    logic [44:0]           quot_prod;
    logic [15:0]           quot;
    logic signed [15:0]    n_sample;

    assign o_cfg_ready = 1'b1;
    assign in_xfer     = i_valid && o_ready;

    assign adv_o   = !r_vo || i_ready;
    assign adv3    = !r_v3 || adv_o;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;
    assign o_valid = r_vo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wave_sel   <= '0;
            r_freq_step  <= '0;
            r_phase_off  <= '0;
            r_volume     <= VOL_RESET;
            r_force_play <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_WAVE_SELECT:    r_wave_sel   <= i_cfg_data[2:0];
                CFG_FREQ_STEP:      r_freq_step  <= i_cfg_data[31:0];
                CFG_PHASE_OFFSET:   r_phase_off  <= i_cfg_data[15:0];
                CFG_VOLUME_PERCENT: r_volume     <= i_cfg_data[6:0];
                CFG_FORCE_PLAY:     r_force_play <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Galois LFSR, shift right
    assign n_lfsr = r_lfsr[0] ? ((r_lfsr >> 1) ^ LFSR_TAPS) : (r_lfsr >> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
            r_lfsr  <= LFSR_SEED;
            r_v1    <= 1'b0;
            r_v2    <= 1'b0;
            r_v3    <= 1'b0;
            r_vo    <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_accum <= r_accum + PHASE_BITS'(r_freq_step);
                r_lfsr  <= n_lfsr;
            end
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
            if (adv_o) r_vo <= r_v3;
        end
    end

    // stage 2: waveform
    always_comb begin
        quad     = r_p1[15:14];
        idx_prod = (IDX_W + 14)'(r_p1[13:0]) * (IDX_W + 14)'(SINE_TABLE_DEPTH);
        idx_fwd  = idx_prod[IDX_W+13:14];
        idx      = quad[0] ? (IDX_W'(SINE_TABLE_DEPTH) - idx_fwd) : idx_fwd;
        sine_mag = (idx == IDX_W'(SINE_TABLE_DEPTH)) ? FULL_SCALE
                                                     : SINE_LUT[idx[LUT_AW-1:0]];
        sine_val = quad[1] ? -$signed({1'b0, sine_mag}) : $signed({1'b0, sine_mag});

        tri_d    = r_p1[15] ? {2'b00, r_p1[14:0]} : (17'd32768 - {2'b00, r_p1[14:0]});
        tri_val  = tri_d[15] ? $signed({1'b0, FULL_SCALE})
                             : $signed({tri_d[14:0], 1'b0} ^ 16'h8000);

        case (r_wave_sel)
            WAVE_SINE:     n_raw = sine_val;
            WAVE_SQUARE: begin
                if (sine_mag <= SQ_DEADBAND) begin
                    n_raw = '0;
                end else begin
                    n_raw = quad[1] ? -$signed({1'b0, FULL_SCALE})
                                    : $signed({1'b0, FULL_SCALE});
                end
            end
            WAVE_TRIANGLE: n_raw = tri_val;
            WAVE_SAWTOOTH: n_raw = $signed({~r_p1[15], r_p1[14:0]});
            WAVE_NOISE:    n_raw = $signed(r_noise1);
            default:       n_raw = '0;
        endcase

        if (!r_act1) begin
            n_raw = '0;
        end
    end

    // stage 3: gain, with rounding bias for the divide
    always_comb begin
        raw_abs  = r_raw2[15] ? (17'd0 - 17'(r_raw2)) : 17'(r_raw2);
        vol_eff  = (r_volume > VOL_MAX) ? VOL_MAX : r_volume;
        num_full = 22'(raw_abs) * 22'(vol_eff) + 22'(ROUND_HALF);
    end

    // output stage: divide by 100, restore sign
    always_comb begin
        quot_prod = 45'(r_num3) * 45'(DIV100_MUL);
        quot      = quot_prod[DIV100_SHIFT +: 16];
        n_sample  = r_neg3 ? $signed(16'd0 - quot) : $signed(quot);
    end

    always_ff @(posedge i_clk) begin
        if (adv1) begin
            r_p1     <= r_accum[PHASE_BITS-1 -: 16] + r_phase_off;
            r_noise1 <= n_lfsr;
            r_act1   <= i_play || r_force_play;
        end
        if (adv2) begin
            r_raw2 <= n_raw;
        end
        if (adv3) begin
            r_num3 <= num_full;
            r_neg3 <= r_raw2[15];
        end
        if (adv_o) begin
            r_sample <= n_sample;
        end
    end

    generate
        if (SAMPLE_BITS >= 16) begin : g_sext
            assign o_sample = SAMPLE_BITS'(r_sample);
        end else begin : g_trunc
            assign o_sample = r_sample[SAMPLE_BITS-1:0];
        end
    endgenerate

    a_lfsr_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lfsr != 16'd0)
        else $error("noise LFSR reached the all-zero lock-up state");

    a_accum_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_accum == $past(r_accum + PHASE_BITS'(r_freq_step)))
        else $error("phase accumulator did not advance by the tuning step");

    a_accum_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !in_xfer |=> $stable(r_accum) && $stable(r_lfsr))
        else $error("phase or noise state moved without an input transfer");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vo && !i_ready |=> r_vo && $stable(r_sample))
        else $error("output register moved while the output was stalled");

endmodule
